[hw/rtl/mtbd_pkg.sv]
// ----------------------------------------------------------------------------
// mtbd_pkg: shared types and constants of the bounded mt19937 draw
// Holds the generator constants, the tempering function, the controller
// state type and the command and status bundles between the two halves.
// ----------------------------------------------------------------------------
package mtbd_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned ValW   = 31;
    localparam int unsigned IdxW   = 10;
    localparam int unsigned StepW  = 5;

    localparam logic [IdxW-1:0]  NumWords  = 10'd624;
    localparam logic [IdxW-1:0]  LastIdx   = 10'd623;
    localparam logic [IdxW-1:0]  FarShift  = 10'd397;
    localparam logic [StepW-1:0] LastStep  = 5'd30;

    localparam logic [WordW-1:0] MatrixA   = 32'h9908_B0DF;
    localparam logic [WordW-1:0] InitMul   = 32'h6C07_8965;
    localparam logic [WordW-1:0] TemperB   = 32'h9D2C_5680;
    localparam logic [WordW-1:0] TemperC   = 32'hEFC6_0000;

    // item codes
    localparam logic FuncReseed = 1'b0;
    localparam logic FuncDraw   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_FIRST,
        ST_SEED_MUL,
        ST_SEED_WRITE,
        ST_READ_PAIR,
        ST_READ_FAR,
        ST_TWIST,
        ST_DIVIDE,
        ST_RESULT
    } mtbd_state_t;

    typedef struct packed {
        logic capture;
        logic seed_first;
        logic seed_mul;
        logic seed_write;
        logic read_far;
        logic twist;
        logic load_out;
    } mtbd_cmd_t;

    typedef struct packed {
        logic seed_last;
        logic div_done;
        logic out_full;
    } mtbd_stat_t;

    // standard output tempering
    function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] y_in);
        logic [WordW-1:0] y;
        y = y_in;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[hw/rtl/mt19937_bounded_draw.sv]
// draw: reads the word pair and far word, twists, then runs the 31-step remainder unit
// reseed: seeds word 0, then a multiply and a write state for each later state word
// next transaction accepted in the cycle after the result loads, none while busy
// a full result register holds the controller in its result state until it drains
// aresetn (synchronous, active low) clears the controller, index and result valid
// state words are undefined until the first reseed
// ----------------------------------------------------------------------------
// mt19937_bounded_draw: mt19937 generator with a bounded draw
// A reseed transaction fills the state words from a seed; a draw transaction
// twists one word, tempers it and returns its low 31 bits modulo the bound.
// ----------------------------------------------------------------------------
module mt19937_bounded_draw
    import mtbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_func,
    input  logic [WordW-1:0] s_seed_value,
    input  logic [ValW-1:0]  s_bound,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ValW-1:0]  m_value
);

    mtbd_cmd_t  cmd;
    mtbd_stat_t stat;

    // controller
    mtbd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath
    mtbd_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_func       (s_func),
        .s_seed_value (s_seed_value),
        .s_bound      (s_bound),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

endmodule

[hw/rtl/mtbd_div.sv]
// ----------------------------------------------------------------------------
// mtbd_div: 31-bit restoring remainder unit
// Produces dividend modulo divisor, one quotient bit per cycle, and pulses
// done for one cycle when the remainder is ready.
// ----------------------------------------------------------------------------
module mtbd_div
    import mtbd_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [ValW-1:0] dividend,
    input  logic [ValW-1:0] divisor,
    output logic            done,
    output logic [ValW-1:0] remainder
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [StepW-1:0]  step_reg, step_next;
    logic [ValW-1:0]   rem_reg, rem_next;
    logic [ValW-1:0]   dvd_reg, dvd_next;
    logic [ValW-1:0]   dvs_reg, dvs_next;
    logic [ValW:0]     trial;

    // one restoring step
    assign trial = {rem_reg, dvd_reg[ValW-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = LastStep;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = ValW'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[ValW-1:0];
            end
            dvd_next = {dvd_reg[ValW-2:0], 1'b0};
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        dvs_reg  <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/mtbd_dp.sv]
// ----------------------------------------------------------------------------
// mtbd_dp: datapath of the bounded mt19937 draw
// State word memory, seeding multiplier, twist and temper logic, the
// remainder unit and the result register.
// ----------------------------------------------------------------------------
module mtbd_dp
    import mtbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  mtbd_cmd_t        cmd,
    output mtbd_stat_t       stat,
    input  logic             s_func,
    input  logic [WordW-1:0] s_seed_value,
    input  logic [ValW-1:0]  s_bound,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ValW-1:0]  m_value
);

    logic [WordW-1:0] mem [NumWords];

    logic             func_reg, func_next;
    logic [WordW-1:0] seed_reg, seed_next;
    logic [ValW-1:0]  bound_reg, bound_next;
    logic [IdxW-1:0]  widx_reg, widx_next;
    logic [IdxW-1:0]  cnt_reg, cnt_next;
    logic [WordW-1:0] prev_reg, prev_next;
    logic [WordW-1:0] prod_reg, prod_next;
    logic [WordW-1:0] y_reg, y_next;
    logic [WordW-1:0] rd_a_reg, rd_b_reg;
    logic             m_valid_reg, m_valid_next;
    logic [ValW-1:0]  m_value_reg, m_value_next;

    logic [IdxW-1:0]  nx_idx, far_idx, rd_a_addr;
    logic [IdxW:0]    far_sum;
    logic [WordW-1:0] mix, tw_word, wr_data;
    logic [WordW-1:0] prod_full;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic             div_done;
    logic [ValW-1:0]  div_rem;

    // cyclic neighbor addresses
    assign nx_idx  = (widx_reg == LastIdx) ? '0 : widx_reg + 1'b1;
    assign far_sum = {1'b0, widx_reg} + {1'b0, FarShift};
    assign far_idx = (far_sum >= {1'b0, NumWords}) ? IdxW'(far_sum - {1'b0, NumWords})
                                                   : far_sum[IdxW-1:0];
    assign rd_a_addr = cmd.read_far ? far_idx : widx_reg;

    // seeding recurrence, low word of the product only
    assign mix       = prev_reg ^ (prev_reg >> 30);
    assign prod_full = mix * InitMul;

    // twist of the current word
    assign tw_word = rd_a_reg ^ (y_reg >> 1) ^ (y_reg[0] ? MatrixA : '0);

    // memory write select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = widx_reg;
        wr_data = tw_word;
        if (cmd.seed_first) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = seed_reg;
        end else if (cmd.seed_write) begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = prod_reg + {{(WordW-IdxW){1'b0}}, cnt_reg};
        end else if (cmd.twist) begin
            wr_en = 1'b1;
        end
    end

    // state word memory, one write and two registered reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[nx_idx];
    end

    // remainder unit
    mtbd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.twist),
        .dividend  (ValW'(temper(tw_word))),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next values of the datapath registers
    always_comb begin
        func_next    = func_reg;
        seed_next    = seed_reg;
        bound_next   = bound_reg;
        widx_next    = widx_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        prod_next    = prod_reg;
        y_next       = y_reg;
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        if (cmd.capture) begin
            func_next  = s_func;
            seed_next  = s_seed_value;
            bound_next = s_bound;
        end
        if (cmd.seed_first) begin
            prev_next = seed_reg;
            cnt_next  = 10'd1;
            widx_next = '0;
        end
        if (cmd.seed_mul) begin
            prod_next = prod_full[WordW-1:0];
        end
        if (cmd.seed_write) begin
            prev_next = wr_data;
            cnt_next  = cnt_reg + 1'b1;
        end
        if (cmd.read_far) begin
            y_next = {rd_a_reg[WordW-1], rd_b_reg[WordW-2:0]};
        end
        if (cmd.twist) begin
            widx_next = nx_idx;
        end
        // result register, a new load wins over the clear
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
            if (func_reg == FuncDraw && bound_reg != '0) begin
                m_value_next = div_rem;
            end else begin
                m_value_next = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            widx_reg    <= widx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        seed_reg    <= seed_next;
        bound_reg   <= bound_next;
        cnt_reg     <= cnt_next;
        prev_reg    <= prev_next;
        prod_reg    <= prod_next;
        y_reg       <= y_next;
        m_value_reg <= m_value_next;
    end

    assign stat.seed_last = (cnt_reg == LastIdx);
    assign stat.div_done  = div_done;
    assign stat.out_full  = m_valid_reg;

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

endmodule

[hw/rtl/mtbd_ctrl.sv]
// ----------------------------------------------------------------------------
// mtbd_ctrl: controller of the bounded mt19937 draw
// Sequences the seeding walk, the read-twist-write of a draw, the remainder
// wait and the hand-off to the result register.
// ----------------------------------------------------------------------------
module mtbd_ctrl
    import mtbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_func,
    output logic       s_ready,
    input  mtbd_stat_t stat,
    output mtbd_cmd_t  cmd
);

    mtbd_state_t state_reg, state_next;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_func == FuncDraw) ? ST_READ_PAIR : ST_SEED_FIRST;
                end
            end
            ST_SEED_FIRST: state_next = ST_SEED_MUL;
            ST_SEED_MUL:   state_next = ST_SEED_WRITE;
            ST_SEED_WRITE: begin
                state_next = stat.seed_last ? ST_RESULT : ST_SEED_MUL;
            end
            ST_READ_PAIR:  state_next = ST_READ_FAR;
            ST_READ_FAR:   state_next = ST_TWIST;
            ST_TWIST:      state_next = ST_DIVIDE;
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!stat.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_SEED_FIRST: cmd.seed_first = 1'b1;
            ST_SEED_MUL:   cmd.seed_mul   = 1'b1;
            ST_SEED_WRITE: cmd.seed_write = 1'b1;
            ST_READ_PAIR:  cmd            = '0;
            ST_READ_FAR:   cmd.read_far   = 1'b1;
            ST_TWIST:      cmd.twist      = 1'b1;
            ST_DIVIDE:     cmd            = '0;
            ST_RESULT:     cmd.load_out   = !stat.out_full;
            default:       cmd            = '0;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[test/tb_mt19937_bounded_draw.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mt19937_bounded_draw: self-checking bench for the bounded mt19937 draw
// Drives reseed and draw transactions through the input channel. A local
// generator model predicts every result value. Each value is checked in
// order as it leaves the result channel. Sender gaps and receiver stalls
// change from phase to phase.
// ----------------------------------------------------------------------------
module tb_mt19937_bounded_draw
    import mtbd_pkg::*;
();

    localparam int unsigned QuietLimit = 20000;
    localparam int unsigned HoldCycles = 300;
    localparam int unsigned PhaseLen   = 80;

    typedef struct {
        logic             func;
        logic [WordW-1:0] seed;
        logic [ValW-1:0]  bound;
        bit               drain_first;
    } mt_cmd_t;

    typedef struct {
        logic            func;
        logic [ValW-1:0] value;
    } mt_value_t;

    logic             aclk         = 1'b0;
    logic             aresetn      = 1'b0;
    logic             s_valid      = 1'b0;
    logic             s_ready;
    logic             s_func       = FuncReseed;
    logic [WordW-1:0] s_seed_value = '0;
    logic [ValW-1:0]  s_bound      = '0;
    logic             m_valid;
    logic             m_ready      = 1'b0;
    logic [ValW-1:0]  m_value;

    mt_cmd_t   cmd_q[$];
    mt_value_t value_due_q[$];

    // local copy of the generator state
    bit [WordW-1:0] mt_words [0:623];
    int unsigned    mt_pos;

    int unsigned n_in;
    int unsigned n_out;
    int unsigned n_reseeds;
    int unsigned n_draws;
    int unsigned n_zero_bound;
    int unsigned n_errors;
    int unsigned offer_mark;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    bit          hold_done;

    mt19937_bounded_draw u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_seed_value (s_seed_value),
        .s_bound      (s_bound),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

    always #5 aclk = ~aclk;

    // standard output tempering
    function automatic bit [WordW-1:0] mt_temper(bit [WordW-1:0] x);
        bit [WordW-1:0] r;
        r = x ^ {11'b0, x[31:11]};
        r = r ^ ({r[24:0], 7'b0} & TemperB);
        r = r ^ ({r[16:0], 15'b0} & TemperC);
        r = r ^ {18'b0, r[31:18]};
        return r;
    endfunction

    // standard seeding walk over all state words
    function automatic void mt_reseed(bit [WordW-1:0] seed);
        bit [WordW-1:0] prev;
        mt_words[0] = seed;
        for (int k = 1; k < 624; k++) begin
            prev        = mt_words[k-1];
            mt_words[k] = InitMul * (prev ^ (prev >> 30)) + 32'(k);
        end
        mt_pos = 0;
    endfunction

    // twist the current word in place, temper it, reduce by the bound
    function automatic bit [ValW-1:0] twist_and_bound(bit [ValW-1:0] bound);
        int unsigned    nx;
        int unsigned    far_idx;
        bit [WordW-1:0] y;
        bit [WordW-1:0] w;
        bit [ValW-1:0]  t;
        nx      = (mt_pos == 623) ? 0 : mt_pos + 1;
        far_idx = (mt_pos + 397) % 624;
        y       = {mt_words[mt_pos][31], mt_words[nx][30:0]};
        w       = mt_words[far_idx] ^ (y >> 1);
        if (y[0]) begin
            w = w ^ MatrixA;
        end
        mt_words[mt_pos] = w;
        mt_pos           = nx;
        t                = ValW'(mt_temper(w));
        if (bound == '0) begin
            return '0;
        end
        return t % bound;
    endfunction

    function automatic bit roll(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int unsigned phase_now();
        return (n_in / PhaseLen) % 4;
    endfunction

    // bounds spread over zero, tiny, mid, full range and power-of-two values
    function automatic logic [ValW-1:0] pick_bound();
        logic [ValW-1:0] b;
        case ($urandom_range(9))
            0: b = '0;
            1: b = ValW'($urandom_range(1, 16));
            2: b = ValW'($urandom_range(1, 1000));
            3: b = ValW'(1) << $urandom_range(30);
            4: b = 31'h7FFF_FFFF - ValW'($urandom_range(0, 64));
            default: begin
                b = ValW'($urandom());
                if (b == '0) begin
                    b = 31'd1;
                end
            end
        endcase
        return b;
    endfunction

    task automatic add_cmd(logic func, logic [WordW-1:0] seed, logic [ValW-1:0] bound,
                           bit drain_first);
        mt_cmd_t c;
        c.func        = func;
        c.seed        = seed;
        c.bound       = bound;
        c.drain_first = drain_first;
        cmd_q.push_back(c);
    endtask

    task automatic report_error(string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // stimulus and end of run
    initial begin
        int unsigned run_len;
        // directed: standard seed, bound extremes, zero bound, seed extremes
        add_cmd(FuncReseed, 32'd5489, ValW'($urandom()), 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'h7FFF_FFFF, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd1, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd0, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd2, 1'b0);
        add_cmd(FuncDraw, 32'hFFFF_FFFF, 31'h4000_0000, 1'b0);
        add_cmd(FuncDraw, 32'h0000_0000, 31'h5555_5555, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'h2AAA_AAAA, 1'b0);
        add_cmd(FuncReseed, 32'h0000_0000, 31'h7FFF_FFFF, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd3, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'h7FFF_FFFF, 1'b0);
        add_cmd(FuncReseed, 32'hFFFF_FFFF, 31'd0, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd10, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'h7FFF_FFFE, 1'b0);
        add_cmd(FuncReseed, 32'hAAAA_AAAA, 31'h5555_5555, 1'b0);
        add_cmd(FuncReseed, 32'h5555_5555, 31'h2AAA_AAAA, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd0, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'd1000, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'h0000_0001, 1'b0);
        add_cmd(FuncDraw, $urandom(), 31'h7FFF_FFFF, 1'b0);
        // one long run past the index wrap, started once the block is drained
        add_cmd(FuncReseed, $urandom(), pick_bound(), 1'b1);
        for (int k = 0; k < 700; k++) begin
            add_cmd(FuncDraw, $urandom(), pick_bound(), 1'b0);
        end
        // shorter runs, sometimes back-to-back reseeds
        while (cmd_q.size() < 1300) begin
            run_len = roll(15) ? 0 : $urandom_range(5, 80);
            add_cmd(FuncReseed, $urandom(), pick_bound(), roll(10));
            for (int k = 0; k < run_len; k++) begin
                add_cmd(FuncDraw, $urandom(), pick_bound(), 1'b0);
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (cmd_q.size() == 0);
        wait (value_due_q.size() == 0);
        repeat (100) @(posedge aclk);

        $display("covered %0d reseeds and %0d draws (%0d with zero bound), %0d results checked",
                 n_reseeds, n_draws, n_zero_bound, n_out);
        $display("sender gaps, receiver stalls, a long receiver hold-off and drain pauses");
        if (n_errors == 0 && value_due_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // driver: offer the next transaction at the falling edge
    always @(negedge aclk) begin
        int unsigned tx_pct;
        tx_pct = (phase_now() == 1) ? 58 : (phase_now() == 3) ? 37 : 0;
        if (aresetn && (!s_valid || n_in != offer_mark)) begin
            if (cmd_q.size() != 0
                && !(cmd_q[0].drain_first && value_due_q.size() != 0)
                && (hold_left != 0 || !roll(tx_pct))) begin
                s_valid      <= 1'b1;
                s_func       <= cmd_q[0].func;
                s_seed_value <= cmd_q[0].seed;
                s_bound      <= cmd_q[0].bound;
                offer_mark   = n_in;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off counted here
    always @(negedge aclk) begin
        int unsigned rx_pct;
        rx_pct = (phase_now() == 2) ? 58 : (phase_now() == 3) ? 37 : 0;
        if (!hold_done && n_in >= 400) begin
            hold_done = 1'b1;
            hold_left = HoldCycles;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && !roll(rx_pct);
        end
    end

    // check results, then predict accepted transactions
    always @(posedge aclk) begin
        mt_value_t due;
        mt_value_t got;
        if (aresetn && m_valid && m_ready) begin
            n_out++;
            if (value_due_q.size() == 0) begin
                report_error($sformatf("result value 0x%08h with nothing expected", m_value));
            end else begin
                due = value_due_q.pop_front();
                if (m_value !== due.value) begin
                    report_error($sformatf("%s value: expected 0x%08h, got 0x%08h",
                                           (due.func == FuncDraw) ? "draw" : "reseed",
                                           due.value, m_value));
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            got.func = s_func;
            if (s_func == FuncReseed) begin
                mt_reseed(s_seed_value);
                got.value = '0;
                n_reseeds++;
            end else begin
                got.value = twist_and_bound(s_bound);
                n_draws++;
                if (s_bound == '0) begin
                    n_zero_bound++;
                end
            end
            value_due_q.push_back(got);
            void'(cmd_q.pop_front());
            n_in++;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QuietLimit) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
